>>> rtl/core/damt_pkg.sv
// Package with the types and constants of the device address map table.
`timescale 1ns / 1ps

package damt_pkg;

   localparam int MAX_RANGES = 16;
   localparam int IDX_W      = $clog2(MAX_RANGES);
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);
   localparam int ADDR_W     = 64;
   localparam int MASK_W     = 20;

   localparam logic [MASK_W-1:0] ALIGN_RESET = MASK_W'(4095);
   localparam logic [ADDR_W-1:0] ALL_ONES    = {ADDR_W{1'b1}};
   localparam logic [3:0]        LAST_MAX    = 4'd15;

   localparam logic [1:0] ACT_INSERT   = 2'd0;
   localparam logic [1:0] ACT_REMOVE   = 2'd1;
   localparam logic [1:0] ACT_SET_LAST = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_OVERLAP = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_BAD_IDX = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] base_addr;
      logic [ADDR_W-1:0] range_length;
      logic [3:0]        entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [4:0]        slot;
      logic [4:0]        entry_count;
      logic [3:0]        last_used;
      logic [ADDR_W-1:0] window_low;
      logic [ADDR_W-1:0] window_high;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base_addr;
      logic [ADDR_W-1:0] end_addr;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHU_RD,
      ST_SHU_WR,
      ST_PLACE,
      ST_SHD_RD,
      ST_SHD_WR,
      ST_DONE
   } state_type;

endpackage

>>> rtl/core/device_address_map_table.sv
// Top level of the device address map table: sorted range store with overlap check.
`timescale 1ns / 1ps

// The block keeps up to MAX_RANGES address ranges sorted by base address in one
// synchronous memory of {base, end} pairs. A request word on req_* asks for an
// insert, a remove by index, or a direct write of the last-used index. Every
// request word gives exactly one response word on rsp_* with status, slot, entry
// count, last-used index and the aligned window of mapped addresses.
// The csr_* channel writes the 20-bit alignment mask; it is always ready and is
// meant to be written while no request is in flight.
// Steps: an insert into a table of n entries at position p passes through decode,
// a scan that reads and then checks each entry until an overlap, a shift that reads
// and then writes each of the n - p entries from p upward, placement and the output
// load. A remove at index i reads and writes the n - 1 - i entries above i to shift
// them down; other requests go from decode straight to the output load.
// One request is worked on at a time; req_ready is high whenever the sequencer is
// idle, so a new word is taken while the previous response still waits.
// When the receiver stalls, the finished response holds in the output register
// and the next request waits at the end of its processing until that slot frees.
// Reset is synchronous: it empties the table, clears the last-used index, sets
// the window to all ones / zero and restores the mask to 4095. Memory contents
// are not cleared; only entries below the count are ever read.
module device_address_map_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  damt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output damt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [19:0]       csr_data
);
   import damt_pkg::*;

   // Range store: one entry per table slot, read data registered.
   entry_type mem [MAX_RANGES];
   entry_type rd_data_ff;

   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   state_type state_ff, state_in;

   req_type           req_ff;
   logic [ADDR_W-1:0] end_ff;      // base + length, wrapped
   logic [ADDR_W-1:0] hi_cand_ff;  // end rounded up to the alignment
   logic [ADDR_W-1:0] prev_end_ff; // end of the entry checked last
   logic [CNT_W-1:0]  ptr_ff;
   logic              pos_valid_ff;
   logic [CNT_W-1:0]  pos_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [3:0]        last_ff;
   logic [ADDR_W-1:0] low_ff;
   logic [ADDR_W-1:0] high_ff;
   logic [MASK_W-1:0] align_ff;
   logic [1:0]        status_ff;
   logic [4:0]        slot_ff;

   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // Scan evaluation of the entry just read.
   logic             below_c;
   logic             above_c;
   logic             overlap_c;
   logic             scan_last_c;
   logic             pos_valid_c;
   logic [CNT_W-1:0] pos_c;
   logic             rsp_load_c;
   logic [CNT_W-1:0] idx_ext_c;
   logic [CNT_W-1:0] cnt_m1_c;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign idx_ext_c  = CNT_W'(req_ff.entry_index);
   assign cnt_m1_c   = count_ff - CNT_W'(1);
   assign rsp_load_c = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      below_c     = (end_ff <= rd_data_ff.base_addr);
      above_c     = (req_ff.base_addr >= rd_data_ff.end_addr);
      overlap_c   = !below_c && !above_c;
      scan_last_c = (ptr_ff == cnt_m1_c);
      pos_valid_c = pos_valid_ff;
      pos_c       = pos_ff;
      if ((ptr_ff == '0) && below_c) begin
         pos_valid_c = 1'b1;
         pos_c       = '0;
      end
      if ((ptr_ff != '0) && below_c && (req_ff.base_addr >= prev_end_ff)) begin
         pos_valid_c = 1'b1;
         pos_c       = ptr_ff;
      end
      if (scan_last_c && above_c) begin
         pos_valid_c = 1'b1;
         pos_c       = ptr_ff + CNT_W'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (req_ff.action)
               ACT_INSERT: begin
                  if (count_ff >= CNT_W'(MAX_RANGES)) state_in = ST_DONE;
                  else if (count_ff == '0)            state_in = ST_PLACE;
                  else                                state_in = ST_SCAN_RD;
               end
               ACT_REMOVE: begin
                  if (idx_ext_c >= count_ff)       state_in = ST_DONE;
                  else if (idx_ext_c == cnt_m1_c)  state_in = ST_DONE;
                  else                             state_in = ST_SHD_RD;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (overlap_c)                state_in = ST_DONE;
            else if (!scan_last_c)        state_in = ST_SCAN_RD;
            else if (!pos_valid_c)        state_in = ST_DONE;
            else if (count_ff > pos_c)    state_in = ST_SHU_RD;
            else                          state_in = ST_PLACE;
         end
         ST_SHU_RD: state_in = ST_SHU_WR;
         ST_SHU_WR: begin
            if ((ptr_ff - CNT_W'(1)) > pos_ff) state_in = ST_SHU_RD;
            else                               state_in = ST_PLACE;
         end
         ST_PLACE: state_in = ST_DONE;
         ST_SHD_RD: state_in = ST_SHD_WR;
         ST_SHD_WR: begin
            if ((ptr_ff + CNT_W'(1)) < count_ff) state_in = ST_SHD_RD;
            else                                 state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load_c) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory control.
   always_comb begin
      rd_addr = ptr_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = ptr_ff[IDX_W-1:0];
      wr_data = rd_data_ff;
      case (state_ff)
         ST_SHU_RD: rd_addr = IDX_W'(ptr_ff - CNT_W'(1));
         ST_SHD_RD: rd_addr = IDX_W'(ptr_ff + CNT_W'(1));
         ST_SHU_WR, ST_SHD_WR: wr_en = 1'b1;
         ST_PLACE: begin
            wr_en             = 1'b1;
            wr_addr           = pos_ff[IDX_W-1:0];
            wr_data.base_addr = req_ff.base_addr;
            wr_data.end_addr  = end_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         low_ff       <= ALL_ONES;
         high_ff      <= '0;
         align_ff     <= ALIGN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) align_ff <= csr_data;
         if (rsp_load_c)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_DECODE: begin
               if ((req_ff.action == ACT_REMOVE) && (idx_ext_c < count_ff)) begin
                  count_ff <= cnt_m1_c;
                  // Removing the top entry leaves the last-used index alone.
                  if ((idx_ext_c != cnt_m1_c) && (req_ff.entry_index <= last_ff) &&
                      (last_ff != '0)) begin
                     last_ff <= last_ff - 4'd1;
                  end
               end
               if (req_ff.action == ACT_SET_LAST) last_ff <= req_ff.entry_index;
            end
            ST_PLACE: begin
               count_ff <= count_ff + CNT_W'(1);
               if (req_ff.base_addr < low_ff) begin
                  low_ff <= req_ff.base_addr & ~ADDR_W'(align_ff);
               end
               if (end_ff > high_ff) high_ff <= hi_cand_ff;
               if ((pos_ff < CNT_W'(last_ff)) && (last_ff < LAST_MAX)) begin
                  last_ff <= last_ff + 4'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // Request datapath; no reset needed.
   always_ff @(posedge clock) begin
      if (rsp_load_c) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.slot        <= slot_ff;
         rsp_ff.entry_count <= 5'(count_ff);
         rsp_ff.last_used   <= last_ff;
         rsp_ff.window_low  <= low_ff;
         rsp_ff.window_high <= high_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_ff <= req_data;
               end_ff <= req_data.base_addr + req_data.range_length;
            end
         end
         ST_DECODE: begin
            hi_cand_ff   <= ((end_ff - ADDR_W'(1)) | ADDR_W'(align_ff)) + ADDR_W'(1);
            ptr_ff       <= '0;
            pos_valid_ff <= 1'b0;
            pos_ff       <= '0;
            status_ff    <= STAT_OK;
            slot_ff      <= '0;
            case (req_ff.action)
               ACT_INSERT: begin
                  if (count_ff >= CNT_W'(MAX_RANGES)) begin
                     status_ff <= STAT_FULL;
                     slot_ff   <= 5'(count_ff);
                  end
               end
               ACT_REMOVE: begin
                  slot_ff <= 5'(req_ff.entry_index);
                  ptr_ff  <= idx_ext_c;
                  if (idx_ext_c >= count_ff) status_ff <= STAT_BAD_IDX;
               end
               default: ;
            endcase
         end
         ST_SCAN_CHK: begin
            pos_valid_ff <= pos_valid_c;
            pos_ff       <= pos_c;
            prev_end_ff  <= rd_data_ff.end_addr;
            if (overlap_c) begin
               status_ff <= STAT_OVERLAP;
               slot_ff   <= 5'(ptr_ff);
            end else if (!scan_last_c) begin
               ptr_ff <= ptr_ff + CNT_W'(1);
            end else if (!pos_valid_c) begin
               // A wrapped end can leave no sorted position.
               status_ff <= STAT_BAD_IDX;
               slot_ff   <= 5'(count_ff);
            end else begin
               ptr_ff <= count_ff;
            end
         end
         ST_SHU_WR: ptr_ff <= ptr_ff - CNT_W'(1);
         ST_PLACE:  slot_ff <= 5'(pos_ff);
         ST_SHD_WR: ptr_ff <= ptr_ff + CNT_W'(1);
         default: ;
      endcase
   end

endmodule
